### rtl/block_cache_replacement_defines.svh
// assertion macros for the block cache replacement table
`ifndef BLOCK_CACHE_REPLACEMENT_DEFINES_SVH
`define BLOCK_CACHE_REPLACEMENT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/bcr_pkg.sv
// shared types and constants of the block cache replacement table
package bcr_pkg;
    localparam int NUM_SLOTS_DEF  = 64;
    localparam int TAG_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FRAC_BITS = 9;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 9'd256;

    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;
    localparam logic [1:0] POL_FBR = 2'd2;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_CAPACITY  = 2'd1;
    localparam logic [1:0] REG_OLD_FRAC  = 2'd2;
    localparam logic [1:0] REG_NEW_FRAC  = 2'd3;

    localparam logic [6:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic accept;
        logic compare;
        logic decide;
        logic tree_load;
        logic tree_step;
        logic take_pos;
        logic read_sel;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic need_tree;
    } t_status;
endpackage

### rtl/bcr_ctrl.sv
// sequencer for one lookup: compare, decide, victim search, read, update
module bcr_ctrl #(
    parameter int NUM_SLOTS = bcr_pkg::NUM_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bcr_pkg::t_status i_status,
    output bcr_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    localparam int LEVELS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW     = $clog2(LEVELS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_TLD  = 3'd3;
    localparam logic [2:0] S_MIN  = 3'd4;
    localparam logic [2:0] S_TAKE = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_lvl, n_lvl;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_TLD;
            end
            S_TLD: begin
                o_cmd.tree_load = 1'b1;
                n_lvl           = LW'(LEVELS);
                n_state         = i_status.need_tree ? S_MIN : S_RD;
            end
            S_MIN: begin
                o_cmd.tree_step = 1'b1;
                n_lvl           = r_lvl - 1'b1;
                if (r_lvl == LW'(1)) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.take_pos = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.read_sel = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

### rtl/bcr_dp.sv
// datapath: row of table cells, key compare, min-count tree, counters
`include "block_cache_replacement_defines.svh"
module bcr_dp #(
    parameter int NUM_SLOTS  = bcr_pkg::NUM_SLOTS_DEF,
    parameter int TAG_BITS   = bcr_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS = bcr_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcr_pkg::t_cmd    i_cmd,
    output bcr_pkg::t_status o_status,
    input  logic [1:0]       i_policy,
    input  logic [6:0]       i_capacity,
    input  logic [8:0]       i_old_fraction,
    input  logic [8:0]       i_new_fraction,
    input  logic [15:0]      i_file_tag,
    input  logic [31:0]      i_block_index,
    output logic             o_valid,
    output logic             o_hit,
    output logic             o_evicted,
    output logic [15:0]      o_evicted_tag,
    output logic [31:0]      o_evicted_index,
    output logic [15:0]      o_use_count,
    output logic [31:0]      o_hit_total,
    output logic [31:0]      o_miss_total
);
    localparam int IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OW   = $clog2(NUM_SLOTS + 1);
    localparam int MW   = (OW > 7) ? OW : 7;
    localparam int PW   = bcr_pkg::FRAC_BITS + OW + 1;
    localparam int HALF = (NUM_SLOTS + 1) / 2;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // table cells, oldest at 0
    logic [TAG_BITS-1:0]   r_tag [NUM_SLOTS];
    logic [31:0]           r_blk [NUM_SLOTS];
    logic [COUNT_BITS-1:0] r_cnt [NUM_SLOTS];
    logic [TAG_BITS-1:0]   n_tag [NUM_SLOTS];
    logic [31:0]           n_blk [NUM_SLOTS];
    logic [COUNT_BITS-1:0] n_cnt [NUM_SLOTS];

    // min-count tree leaves
    logic [COUNT_BITS-1:0] r_tcnt [NUM_SLOTS];
    logic [IW-1:0]         r_tidx [NUM_SLOTS];
    logic                  r_tvld [NUM_SLOTS];
    logic [COUNT_BITS-1:0] n_tcnt [NUM_SLOTS];
    logic [IW-1:0]         n_tidx [NUM_SLOTS];
    logic                  n_tvld [NUM_SLOTS];

    logic [TAG_BITS-1:0]   r_key_tag;
    logic [31:0]           r_key_blk;
    logic [NUM_SLOTS-1:0]  r_match;
    logic [OW-1:0]         r_new_start, r_old_end;
    logic [OW-1:0]         r_occ;
    logic                  r_hit, r_evict;
    logic [IW-1:0]         r_pos;
    logic [TAG_BITS-1:0]   r_sel_tag;
    logic [31:0]           r_sel_blk;
    logic [COUNT_BITS-1:0] r_sel_cnt;
    logic [31:0]           r_hits, r_misses;

    logic [8:0]            nf_sat, of_sat;
    logic [PW-1:0]         new_prod, old_prod;
    logic [OW-1:0]         new_len, old_raw, old_clip;
    logic [MW-1:0]         cap_eff;
    logic [IW-1:0]         first_idx;
    logic [TAG_BITS-1:0]   or_tag;
    logic [31:0]           or_blk;
    logic [COUNT_BITS-1:0] or_cnt;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  bump;
    logic [OW-1:0]         last;
    logic                  shift_en;

    // section bounds from occupancy
    always_comb begin
        nf_sat   = (i_new_fraction > bcr_pkg::FRAC_ONE) ? bcr_pkg::FRAC_ONE : i_new_fraction;
        of_sat   = (i_old_fraction > bcr_pkg::FRAC_ONE) ? bcr_pkg::FRAC_ONE : i_old_fraction;
        new_prod = PW'(nf_sat) * PW'(r_occ) + PW'(255);
        old_prod = PW'(of_sat) * PW'(r_occ);
        new_len  = OW'(new_prod >> 8);
        old_raw  = OW'(old_prod >> 8);
        old_clip = (old_raw < OW'(1)) ? OW'(1) : old_raw;
        if (old_clip > r_occ) begin
            old_clip = r_occ;
        end
    end

    // effective capacity
    always_comb begin
        if (i_capacity == 7'd0) begin
            cap_eff = MW'(1);
        end else if (MW'(i_capacity) > MW'(NUM_SLOTS)) begin
            cap_eff = MW'(NUM_SLOTS);
        end else begin
            cap_eff = MW'(i_capacity);
        end
    end

    // first matching cell
    always_comb begin
        first_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                first_idx = IW'(i);
            end
        end
    end

    // read of the selected cell
    always_comb begin
        or_tag = '0;
        or_blk = '0;
        or_cnt = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_pos == IW'(i)) begin
                or_tag = or_tag | r_tag[i];
                or_blk = or_blk | r_blk[i];
                or_cnt = or_cnt | r_cnt[i];
            end
        end
    end

    // count of the entry written at the recent end
    always_comb begin
        bump = (i_policy == bcr_pkg::POL_LFU) ||
               ((i_policy == bcr_pkg::POL_FBR) && (OW'(r_pos) < r_new_start));
        if (r_hit) begin
            wr_cnt = (bump && (r_sel_cnt < CMAX)) ? r_sel_cnt + 1'b1 : r_sel_cnt;
        end else begin
            wr_cnt = COUNT_BITS'(1);
        end
        shift_en = r_hit || r_evict;
        last     = shift_en ? r_occ - 1'b1 : r_occ;
    end

    // cell next values: shift down from the selected cell, write at the end
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_tag[i] = r_tag[i];
            n_blk[i] = r_blk[i];
            n_cnt[i] = r_cnt[i];
            if (i_cmd.update) begin
                if (OW'(i) == last) begin
                    n_tag[i] = r_hit ? r_sel_tag : r_key_tag;
                    n_blk[i] = r_hit ? r_sel_blk : r_key_blk;
                    n_cnt[i] = wr_cnt;
                end else if (shift_en && (i + 1 < NUM_SLOTS) && (IW'(i) >= r_pos) &&
                             (OW'(i) < last)) begin
                    n_tag[i] = r_tag[(i + 1) % NUM_SLOTS];
                    n_blk[i] = r_blk[(i + 1) % NUM_SLOTS];
                    n_cnt[i] = r_cnt[(i + 1) % NUM_SLOTS];
                end
            end
        end
    end

    // tree load and one halving level
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_tcnt[i] = r_tcnt[i];
            n_tidx[i] = r_tidx[i];
            n_tvld[i] = r_tvld[i];
            if (i_cmd.tree_load) begin
                n_tcnt[i] = r_cnt[i];
                n_tidx[i] = IW'(i);
                n_tvld[i] = (OW'(i) < ((i_policy == bcr_pkg::POL_FBR) ? r_old_end : r_occ));
            end else if (i_cmd.tree_step && (i < HALF)) begin
                if ((2 * i + 1 < NUM_SLOTS) && r_tvld[(2 * i + 1) % NUM_SLOTS] &&
                    (!r_tvld[(2 * i) % NUM_SLOTS] ||
                     (r_tcnt[(2 * i + 1) % NUM_SLOTS] < r_tcnt[(2 * i) % NUM_SLOTS]))) begin
                    n_tcnt[i] = r_tcnt[(2 * i + 1) % NUM_SLOTS];
                    n_tidx[i] = r_tidx[(2 * i + 1) % NUM_SLOTS];
                    n_tvld[i] = 1'b1;
                end else begin
                    n_tcnt[i] = r_tcnt[(2 * i) % NUM_SLOTS];
                    n_tidx[i] = r_tidx[(2 * i) % NUM_SLOTS];
                    n_tvld[i] = r_tvld[(2 * i) % NUM_SLOTS];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            r_tag[i]  <= n_tag[i];
            r_blk[i]  <= n_blk[i];
            r_cnt[i]  <= n_cnt[i];
            r_tcnt[i] <= n_tcnt[i];
            r_tidx[i] <= n_tidx[i];
            r_tvld[i] <= n_tvld[i];
        end
        if (i_cmd.accept) begin
            r_key_tag <= TAG_BITS'(i_file_tag);
            r_key_blk <= i_block_index;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_match[i] <= (OW'(i) < r_occ) && (r_tag[i] == r_key_tag) &&
                              (r_blk[i] == r_key_blk);
            end
            r_new_start <= r_occ - new_len;
            r_old_end   <= old_clip;
        end
        if (i_cmd.read_sel) begin
            r_sel_tag <= or_tag;
            r_sel_blk <= or_blk;
            r_sel_cnt <= or_cnt;
        end
        if (i_cmd.update) begin
            o_evicted_tag   <= r_evict ? 16'(r_sel_tag) : 16'd0;
            o_evicted_index <= r_evict ? r_sel_blk : 32'd0;
            o_use_count     <= 16'(wr_cnt);
            o_hit           <= r_hit;
            o_evicted       <= r_evict;
            o_hit_total     <= r_hit ? r_hits + 1'b1 : r_hits;
            o_miss_total    <= r_hit ? r_misses : r_misses + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_hit    <= 1'b0;
            r_evict  <= 1'b0;
            r_pos    <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= i_cmd.update;
            if (i_cmd.decide) begin
                r_hit   <= |r_match;
                r_evict <= !(|r_match) && (MW'(r_occ) >= cap_eff) && (r_occ != '0);
                r_pos   <= (|r_match) ? first_idx : '0;
            end
            if (i_cmd.take_pos) begin
                r_pos <= r_tidx[0];
            end
            if (i_cmd.update) begin
                if (r_hit) begin
                    r_hits <= r_hits + 1'b1;
                end else begin
                    r_misses <= r_misses + 1'b1;
                    if (!r_evict) begin
                        r_occ <= r_occ + 1'b1;
                    end
                end
            end
        end
    end

    assign o_status.need_tree = r_evict &&
        ((i_policy == bcr_pkg::POL_LFU) || (i_policy == bcr_pkg::POL_FBR));

    `BCR_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= OW'(NUM_SLOTS), "occupancy above slots")
    `BCR_ASSERT(a_evict_miss, i_clk, i_rst_n, r_evict |-> !r_hit, "eviction on a hit")
    `BCR_ASSERT(a_miss_count, i_clk, i_rst_n, (i_cmd.update && !r_hit) |=> (r_misses == $past(r_misses) + 32'd1), "miss total not advanced")
    `BCR_ASSERT_ALWAYS(a_strobe, i_clk, o_valid |-> $past(i_cmd.update), "strobe without update")
endmodule

### rtl/block_cache_replacement.sv
// top level of the block cache replacement table
// One lookup per start; busy stays high while it is worked on. A hit or a
// miss without victim search passes compare, decide, tree load, read and
// update before the result strobe; a miss that evicts under the count
// policies also searches the halving min-count tree over the table cells.
// The result is shown for one cycle with o_valid and cannot be stalled; a
// new start is taken in that same cycle. Configuration writes are always
// ready and must be made while busy is low.
module block_cache_replacement #(
    parameter int NUM_SLOTS  = bcr_pkg::NUM_SLOTS_DEF,
    parameter int TAG_BITS   = bcr_pkg::TAG_BITS_DEF,
    parameter int COUNT_BITS = bcr_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_file_tag,
    input  logic [31:0] i_block_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_hit,
    output logic        o_evicted,
    output logic [15:0] o_evicted_tag,
    output logic [31:0] o_evicted_index,
    output logic [15:0] o_use_count,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);
    logic [1:0]       r_policy;
    logic [6:0]       r_capacity;
    logic [8:0]       r_old_frac, r_new_frac;
    bcr_pkg::t_cmd    cmd;
    bcr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    // configuration registers, one beat per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= bcr_pkg::POL_LRU;
            r_capacity <= bcr_pkg::CAP_RESET;
            r_old_frac <= '0;
            r_new_frac <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bcr_pkg::REG_POLICY:   r_policy   <= i_cfg_data[1:0];
                bcr_pkg::REG_CAPACITY: r_capacity <= i_cfg_data[6:0];
                bcr_pkg::REG_OLD_FRAC: r_old_frac <= i_cfg_data;
                bcr_pkg::REG_NEW_FRAC: r_new_frac <= i_cfg_data;
                default: r_policy <= r_policy;
            endcase
        end
    end

    bcr_ctrl #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bcr_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TAG_BITS  (TAG_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_policy       (r_policy),
        .i_capacity     (r_capacity),
        .i_old_fraction (r_old_frac),
        .i_new_fraction (r_new_frac),
        .i_file_tag     (i_file_tag),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_tag  (o_evicted_tag),
        .o_evicted_index(o_evicted_index),
        .o_use_count    (o_use_count),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total)
    );
endmodule

### sim/block_cache_replacement_test.sv
// self-checking testbench for the block cache replacement table
`timescale 1ns / 1ps

module block_cache_replacement_test;
    localparam int SLOTS = bcr_pkg::NUM_SLOTS_DEF;
    // undefined policy code, must act as lru
    localparam logic [1:0] POL_SPARE = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [15:0] ev_tag;
        logic [31:0] ev_index;
        logic [15:0] use_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_lookup_res;

    typedef enum logic { ROW_LOOKUP, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  reg_index;
        logic [8:0]  reg_data;
        logic [15:0] tag;
        logic [31:0] blk;
        bit          typed;
        t_lookup_res res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_file_tag = '0;
    logic [31:0] i_block_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        o_hit;
    logic        o_evicted;
    logic [15:0] o_evicted_tag;
    logic [31:0] o_evicted_index;
    logic [15:0] o_use_count;
    logic [31:0] o_hit_total;
    logic [31:0] o_miss_total;

    block_cache_replacement u_top (.*);

    // predictor state: table contents and register copies
    logic [15:0] tbl_tag  [SLOTS];
    logic [31:0] tbl_blk  [SLOTS];
    logic [15:0] tbl_uses [SLOTS];
    int          tbl_occ = 0;
    logic [31:0] hits_cnt = '0;
    logic [31:0] misses_cnt = '0;
    logic [1:0]  cfg_policy = bcr_pkg::POL_LRU;
    logic [6:0]  cfg_cap = bcr_pkg::CAP_RESET;
    logic [8:0]  cfg_old = '0;
    logic [8:0]  cfg_new = '0;

    t_lookup_res pending_lookups[$];
    t_stim_row   lookup_rows[$];
    bit          cur_typed = 0;
    t_lookup_res cur_res = '0;
    int          mismatches = 0;
    int          idle_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sat_frac(input logic [8:0] f);
        return (f > 9'd256) ? 256 : int'(f);
    endfunction

    // move an entry to the most-recent end, shifting later ones down
    function automatic void shift_to_end(input int pos);
        logic [15:0] t;
        logic [31:0] b;
        logic [15:0] u;
        t = tbl_tag[pos];
        b = tbl_blk[pos];
        u = tbl_uses[pos];
        for (int i = pos; i + 1 < tbl_occ; i++) begin
            tbl_tag[i]  = tbl_tag[i + 1];
            tbl_blk[i]  = tbl_blk[i + 1];
            tbl_uses[i] = tbl_uses[i + 1];
        end
        tbl_tag[tbl_occ - 1]  = t;
        tbl_blk[tbl_occ - 1]  = b;
        tbl_uses[tbl_occ - 1] = u;
    endfunction

    // least count among the first stop entries, earliest on ties
    function automatic int least_used(input int stop);
        int best;
        best = 0;
        for (int i = 1; i < stop; i++)
            if (tbl_uses[i] < tbl_uses[best]) best = i;
        return best;
    endfunction

    function automatic t_lookup_res predict_lookup(input logic [15:0] tag,
                                                   input logic [31:0] blk);
        t_lookup_res r;
        int n, cap, found, victim, old_end, new_start;
        logic bump;
        r = '0;
        n = tbl_occ;
        cap = int'(cfg_cap);
        if (cap == 0) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        found = n;
        for (int i = 0; i < n; i++)
            if (found == n && tbl_tag[i] == tag && tbl_blk[i] == blk) found = i;
        if (found < n) begin
            new_start = n - ((sat_frac(cfg_new) * n + 255) >> 8);
            bump = (cfg_policy == bcr_pkg::POL_LFU) ||
                   (cfg_policy == bcr_pkg::POL_FBR && found < new_start);
            if (bump && tbl_uses[found] != 16'hFFFF) tbl_uses[found]++;
            shift_to_end(found);
            r.hit = 1'b1;
            r.use_count = tbl_uses[n - 1];
            hits_cnt++;
        end else begin
            misses_cnt++;
            if (n >= cap && n > 0) begin
                if (cfg_policy == bcr_pkg::POL_LFU) begin
                    victim = least_used(n);
                end else if (cfg_policy == bcr_pkg::POL_FBR) begin
                    old_end = (sat_frac(cfg_old) * n) >> 8;
                    if (old_end < 1) old_end = 1;
                    if (old_end > n) old_end = n;
                    victim = least_used(old_end);
                end else begin
                    victim = 0;
                end
                r.evicted = 1'b1;
                r.ev_tag = tbl_tag[victim];
                r.ev_index = tbl_blk[victim];
                shift_to_end(victim);
                tbl_occ = n - 1;
            end
            if (tbl_occ < SLOTS) begin
                tbl_tag[tbl_occ] = tag;
                tbl_blk[tbl_occ] = blk;
                tbl_uses[tbl_occ] = 16'd1;
                tbl_occ++;
            end
            r.use_count = 16'd1;
        end
        r.hit_total = hits_cnt;
        r.miss_total = misses_cnt;
        return r;
    endfunction

    // monitor: predict on accepted lookups, check each result strobe
    always @(posedge i_clk) begin
        t_lookup_res got, want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{o_hit, o_evicted, o_evicted_tag, o_evicted_index,
                        o_use_count, o_hit_total, o_miss_total};
                if (pending_lookups.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = pending_lookups.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (start && !busy) begin
                want = predict_lookup(i_file_tag, i_block_index);
                pending_lookups.insert(pending_lookups.size(), cur_typed ? cur_res : want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bcr_pkg::REG_POLICY:   cfg_policy = i_cfg_data[1:0];
                    bcr_pkg::REG_CAPACITY: cfg_cap = i_cfg_data[6:0];
                    bcr_pkg::REG_OLD_FRAC: cfg_old = i_cfg_data;
                    bcr_pkg::REG_NEW_FRAC: cfg_new = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    task automatic send_lookup(input logic [15:0] tag, input logic [31:0] blk,
                               input bit typed, input t_lookup_res res);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start = 1'b1;
        i_file_tag = tag;
        i_block_index = blk;
        cur_typed = typed;
        cur_res = res;
        do @(posedge i_clk); while (busy);
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_lookups.size() != 0 || busy) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [8:0] data);
        t_stim_row row;
        row = '{ROW_CFG, idx, data, 16'd0, 32'd0, 0, '0};
        lookup_rows.insert(lookup_rows.size(), row);
    endtask

    task automatic add_look(input logic [15:0] tag, input logic [31:0] blk);
        t_stim_row row;
        row = '{ROW_LOOKUP, bcr_pkg::REG_POLICY, 9'd0, tag, blk, 0, '0};
        lookup_rows.insert(lookup_rows.size(), row);
    endtask

    task automatic add_look_typed(input logic [15:0] tag, input logic [31:0] blk,
                                  input t_lookup_res res);
        t_stim_row row;
        row = '{ROW_LOOKUP, bcr_pkg::REG_POLICY, 9'd0, tag, blk, 1, res};
        lookup_rows.insert(lookup_rows.size(), row);
    endtask

    function automatic logic [8:0] pick_frac();
        case ($urandom_range(4))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'd511;
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    function automatic logic [8:0] pick_cap();
        case ($urandom_range(7))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd64;
            3: return 9'd127;
            4: return 9'($urandom_range(511));
            default: return 9'($urandom_range(2, 12));
        endcase
    endfunction

    initial begin
        logic [15:0] pool_tag [24];
        logic [31:0] pool_blk [24];
        int k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, hit, all-ones key, lru, lfu, fbr, odd settings
        add_look_typed(16'h0000, 32'h0, '{0, 0, 16'h0, 32'h0, 16'd1, 32'd0, 32'd1});
        add_look_typed(16'h0000, 32'h0, '{1, 0, 16'h0, 32'h0, 16'd1, 32'd1, 32'd1});
        add_look_typed(16'hFFFF, 32'hFFFFFFFF,
                       '{0, 0, 16'h0, 32'h0, 16'd1, 32'd1, 32'd2});
        add_cfg(bcr_pkg::REG_CAPACITY, 9'd2);
        add_look_typed(16'h0001, 32'h1, '{0, 1, 16'h0, 32'h0, 16'd1, 32'd1, 32'd3});
        add_cfg(bcr_pkg::REG_POLICY, 9'(bcr_pkg::POL_LFU));
        add_look_typed(16'h0001, 32'h1, '{1, 0, 16'h0, 32'h0, 16'd2, 32'd2, 32'd3});
        add_look_typed(16'h0002, 32'h2,
                       '{0, 1, 16'hFFFF, 32'hFFFFFFFF, 16'd1, 32'd2, 32'd4});
        add_cfg(bcr_pkg::REG_POLICY, 9'(bcr_pkg::POL_FBR));
        add_cfg(bcr_pkg::REG_OLD_FRAC, 9'd256);
        add_cfg(bcr_pkg::REG_NEW_FRAC, 9'd128);
        add_cfg(bcr_pkg::REG_CAPACITY, 9'd127);
        add_look(16'h0003, 32'h3);
        add_look(16'h0004, 32'h4);
        add_look(16'h0001, 32'h1);
        add_look(16'h0003, 32'h3);
        // fractions above one, and sections overlapping
        add_cfg(bcr_pkg::REG_OLD_FRAC, 9'd511);
        add_cfg(bcr_pkg::REG_NEW_FRAC, 9'd511);
        add_look(16'h0002, 32'h2);
        add_look(16'h0005, 32'h5);
        // capacity zero acts as one: each miss evicts an entry and occupancy holds
        add_cfg(bcr_pkg::REG_CAPACITY, 9'd0);
        add_look(16'h0006, 32'h6);
        add_look(16'h0007, 32'h7);
        add_cfg(bcr_pkg::REG_POLICY, 9'(POL_SPARE));
        add_look(16'hAAAA, 32'h55555555);
        add_look(16'h5555, 32'hAAAAAAAA);

        foreach (lookup_rows[r]) begin
            if (lookup_rows[r].kind == ROW_CFG)
                write_reg(lookup_rows[r].reg_index, lookup_rows[r].reg_data);
            else
                send_lookup(lookup_rows[r].tag, lookup_rows[r].blk,
                            lookup_rows[r].typed, lookup_rows[r].res);
        end

        // random phases: new settings and key pool each time
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = (ph < 3) ? 6 : (ph < 6) ? 71 : 0;
            write_reg(bcr_pkg::REG_POLICY, 9'($urandom_range(511)));
            write_reg(bcr_pkg::REG_CAPACITY, pick_cap());
            write_reg(bcr_pkg::REG_OLD_FRAC, pick_frac());
            write_reg(bcr_pkg::REG_NEW_FRAC, pick_frac());
            for (int p = 0; p < 24; p++) begin
                pool_tag[p] = 16'($urandom);
                pool_blk[p] = $urandom;
            end
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(9) == 0) begin
                    send_lookup(16'($urandom), $urandom, 0, '0);
                end else begin
                    k = $urandom_range(($urandom_range(1)) ? 7 : 23);
                    send_lookup(pool_tag[k], pool_blk[k], 0, '0);
                end
            end
        end
        @(negedge i_clk);
        start = 1'b0;
        cur_typed = 0;

        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("block_cache_replacement regression: pass");
        else
            $display("block_cache_replacement regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("block_cache_replacement regression: fail");
        $finish;
    end
endmodule
